// ===== src/dfb_pkg.sv =====
// Package for the domino flip balance search block.
// Holds the channel payload types and the fixed field widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dfb_pkg;

  // Field widths fixed by the channel definitions
  localparam int FACE_W  = 3;
  localparam int DIFF_W  = 8;
  localparam int MASK_W  = 28;
  localparam int ONES_W  = 5;

  // Running row difference: |sum| <= 28 * 7 = 196, so 9 bits signed
  localparam int SUM_W   = 9;
  // Per-tile face difference and its doubled form
  localparam int DELTA_W = FACE_W + 1;
  localparam int DBL_W   = DELTA_W + 1;

  // Best difference before any pattern is tried
  localparam logic [DIFF_W-1:0] START_BEST = DIFF_W'(168);

  typedef struct packed {
    logic [FACE_W-1:0] top_face;
    logic [FACE_W-1:0] bottom_face;
    logic              last_tile;
  } tile_t;

  typedef struct packed {
    logic [DIFF_W-1:0] least_difference;
    logic [MASK_W-1:0] flip_mask;
    logic [ONES_W-1:0] flipped_count;
  } result_t;

endpackage

`default_nettype wire

// ===== src/domino_flip_balance_search.sv =====
// Domino flip balance search: loads tiles into a face RAM, then walks every
// flip pattern as a counter, one carry digit per RAM read. Uses dfb_pkg, dfb_ram.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------
//   tile     | in        | tile_valid / tile_stall   | tile_t (one domino)
//   result   | out       | result_valid / result_stall | result_t (best flip)
//
// Tiles are taken as offered while loading. After the marked tile the search
// runs a compare state for each pattern and a walk state for each counter digit
// that the increment touches (one face RAM read each); a zero difference ends it
// early. Reset is synchronous; the face RAM is not cleared, and only entries
// below the tile count are ever used. A stalled result waits in the output
// register while new tiles load; a search that finishes meanwhile holds until
// that register is free.
`timescale 1ns / 1ps
`default_nettype none

module domino_flip_balance_search
  import dfb_pkg::*;
#(
  parameter int MAX_TILES = 28
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    tile_valid,
  output logic         tile_stall,
  input  wire tile_t   tile,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);
  localparam int RW = 2 * FACE_W;

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]              state;
  logic [CW-1:0]           count;
  logic signed [SUM_W-1:0] load_sum;
  logic signed [SUM_W-1:0] sum;
  logic [AW-1:0]           slot;
  logic [MASK_W-1:0]       trial_mask;
  logic [ONES_W-1:0]       trial_ones;
  logic [DIFF_W-1:0]       best_diff;
  logic [MASK_W-1:0]       best_mask;
  logic [ONES_W-1:0]       best_ones;

  logic                    tile_xfer;
  logic                    store_tile;
  logic signed [SUM_W-1:0] load_sum_next;
  logic signed [DELTA_W-1:0] in_delta;
  logic [AW-1:0]           last_slot;
  logic [AW-1:0]           rd_addr;
  logic [RW-1:0]           rd_data;
  logic signed [DELTA_W-1:0] rd_delta;
  logic signed [SUM_W-1:0] rd_dbl;
  logic signed [SUM_W-1:0] abs_sum;
  logic [DIFF_W-1:0]       diff;
  logic                    improve;
  logic                    out_free;

  assign tile_stall = (state != ST_LOAD);
  assign tile_xfer  = tile_valid && !tile_stall;
  assign store_tile = tile_xfer && (count < CW'(MAX_TILES));

  // Running sum of top minus bottom over the stored tiles
  assign in_delta      = $signed({1'b0, tile.top_face}) - $signed({1'b0, tile.bottom_face});
  assign load_sum_next = store_tile ? load_sum + SUM_W'(in_delta) : load_sum;

  // Counter digit zero is the highest held slot
  assign last_slot = AW'(count - CW'(1));
  assign rd_addr   = (state == ST_EVAL) ? last_slot : slot - AW'(1);

  dfb_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_TILES)
  ) u_faces (
    .clk     (clk),
    .wr_en   (store_tile),
    .wr_addr (AW'(count)),
    .wr_data ({tile.top_face, tile.bottom_face}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Doubled face difference of the slot being carried through
  assign rd_delta = $signed({1'b0, rd_data[RW-1:FACE_W]})
                  - $signed({1'b0, rd_data[FACE_W-1:0]});
  assign rd_dbl   = SUM_W'(rd_delta) <<< 1;

  // Absolute row difference of the current pattern
  assign abs_sum = sum[SUM_W-1] ? -sum : sum;
  assign diff    = abs_sum[DIFF_W-1:0];
  assign improve = diff < best_diff;

  assign out_free = !result_valid || !result_stall;

  // Sequencer: load, compare, carry walk, hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      count        <= '0;
      load_sum     <= '0;
      sum          <= '0;
      slot         <= '0;
      trial_mask   <= '0;
      trial_ones   <= '0;
      best_diff    <= START_BEST;
      best_mask    <= '0;
      best_ones    <= '0;
      result_valid <= 1'b0;
    end else begin
      // Raise the result on hand-off, drop it once it is transferred
      if (state == ST_FINISH && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_LOAD: begin
          if (tile_xfer) begin
            load_sum <= load_sum_next;
            if (store_tile) begin
              count <= count + CW'(1);
            end
            if (tile.last_tile) begin
              sum        <= load_sum_next;
              trial_mask <= '0;
              trial_ones <= '0;
              best_diff  <= START_BEST;
              best_mask  <= '0;
              best_ones  <= '0;
              state      <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          if (improve) begin
            best_diff <= diff;
            best_mask <= trial_mask;
            best_ones <= trial_ones;
          end
          slot <= last_slot;
          if (improve && diff == '0) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (trial_mask[slot]) begin
            // Clear the digit and carry on to the next lower slot
            trial_mask[slot] <= 1'b0;
            trial_ones       <= trial_ones - ONES_W'(1);
            sum              <= sum + rd_dbl;
            slot             <= slot - AW'(1);
            if (slot == '0) begin
              state <= ST_FINISH;
            end
          end else begin
            trial_mask[slot] <= 1'b1;
            trial_ones       <= trial_ones + ONES_W'(1);
            sum              <= sum - rd_dbl;
            state            <= ST_EVAL;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            count        <= '0;
            load_sum     <= '0;
            state        <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      result.least_difference <= best_diff;
      result.flip_mask        <= best_mask;
      result.flipped_count    <= best_ones;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TILES))
    else $error("tile count beyond capacity");

  a_ones_track: assert property (@(posedge clk) disable iff (rst)
    (best_ones == ONES_W'($countones(best_mask))) &&
    (trial_ones == ONES_W'($countones(trial_mask))))
    else $error("flip counters out of step with masks");

  a_best_falls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL || state == ST_WALK) |=> best_diff <= $past(best_diff))
    else $error("best difference grew during search");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL || state == ST_WALK) |-> count != '0)
    else $error("search started with no tiles");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !out_free) |=> state == ST_FINISH)
    else $error("search result left before output register was free");

endmodule

`default_nettype wire

// ===== src/dfb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies; used for the tile face store.
`timescale 1ns / 1ps
`default_nettype none

module dfb_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 28
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== verif/domino_flip_balance_search_test.sv =====
// Self-checking testbench for domino_flip_balance_search.
// Runs a directed table, then random tile sets with random gaps and stalls.
// Results are checked against a built-in flip search or a fixed expected value. Depends on dfb_pkg.
`timescale 1ns / 1ps

module domino_flip_balance_search_test;
  import dfb_pkg::*;

  localparam int TILE_SLOTS  = 28;
  localparam int RANDOM_TILES = 800;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    tile_t   t;
    bit      typed;
    result_t want;
  } table_row_t;

  logic    clk;
  logic    rst;
  logic    tile_valid;
  logic    tile_stall;
  tile_t   tile;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  // Tiles held by the search model, as the block holds them
  logic [FACE_W-1:0] held_top[TILE_SLOTS];
  logic [FACE_W-1:0] held_bottom[TILE_SLOTS];
  int                held_count;

  result_t    expected_results[$];
  table_row_t directed_rows[$];
  int         mismatch_count;
  int         tiles_sent;
  int         stall_left;
  int         cycle_count;
  bit         quiet;

  domino_flip_balance_search dut (
    .clk         (clk),
    .rst         (rst),
    .tile_valid  (tile_valid),
    .tile_stall  (tile_stall),
    .tile        (tile),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk every flip pattern of the held tiles in counting order, tile 1 as
  // the top digit, and keep the first pattern with the least difference.
  function automatic result_t best_flip();
    int                delta[TILE_SLOTS];
    int                run;
    int                diff;
    int                best;
    int                slot;
    int                j;
    logic [MASK_W-1:0] trial;
    logic [MASK_W-1:0] best_mask;
    bit                done;
    bit                moved;
    result_t           r;
    run = 0;
    for (j = 0; j < held_count; j++) begin
      delta[j] = int'(held_top[j]) - int'(held_bottom[j]);
      run += delta[j];
    end
    best = 168;
    best_mask = '0;
    trial = '0;
    done = 1'b0;
    while (!done) begin
      diff = (run < 0) ? -run : run;
      if (diff < best) begin
        best = diff;
        best_mask = trial;
      end
      if (best == 0) begin
        done = 1'b1;
      end else begin
        // Advance the pattern counter; a carry out of the top digit ends it
        j = 0;
        moved = 1'b0;
        while (j < held_count && !moved) begin
          slot = held_count - 1 - j;
          if (trial[slot]) begin
            trial[slot] = 1'b0;
            run += 2 * delta[slot];
          end else begin
            trial[slot] = 1'b1;
            run -= 2 * delta[slot];
            moved = 1'b1;
          end
          j++;
        end
        if (!moved) done = 1'b1;
      end
    end
    r.least_difference = best[DIFF_W-1:0];
    r.flip_mask        = best_mask;
    r.flipped_count    = ONES_W'($countones(best_mask));
    return r;
  endfunction

  // Mostly no idling, some short gaps, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one tile, wait for its transfer, update the model, then idle
  task automatic send_tile(input tile_t t, input bit typed, input result_t want);
    int gap;
    @(negedge clk);
    tile_valid <= 1'b1;
    tile       <= t;
    @(posedge clk);
    while (tile_stall) @(posedge clk);
    tiles_sent++;
    if (held_count < TILE_SLOTS) begin
      held_top[held_count]    = t.top_face;
      held_bottom[held_count] = t.bottom_face;
      held_count++;
    end
    if (t.last_tile) begin
      expected_results.push_back(typed ? want : best_flip());
      held_count = 0;
    end
    gap = idle_length();
    if (gap > 0) begin
      @(negedge clk);
      tile_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    tile_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input int top, input int bottom, input bit last, input bit typed,
                         input int diff, input int mask, input int count);
    table_row_t row;
    row.t.top_face          = FACE_W'(top);
    row.t.bottom_face       = FACE_W'(bottom);
    row.t.last_tile         = last;
    row.typed               = typed;
    row.want.least_difference = DIFF_W'(diff);
    row.want.flip_mask        = MASK_W'(mask);
    row.want.flipped_count    = ONES_W'(count);
    directed_rows.push_back(row);
  endtask

  task automatic send_random_set(input int n);
    tile_t t;
    int    i;
    for (i = 0; i < n; i++) begin
      t.top_face    = FACE_W'($urandom_range(0, 7));
      t.bottom_face = FACE_W'($urandom_range(0, 7));
      t.last_tile   = (i == n - 1);
      send_tile(t, 1'b0, '0);
    end
  endtask

  // Build a set whose running difference stays within one tile's range, and
  // close it with a tile that cancels it either as placed or once flipped, so
  // the search finds zero at once. Dropped tiles past the full set follow.
  task automatic send_balanced_set(input int n, input int dropped);
    tile_t             t;
    logic [FACE_W-1:0] swap;
    int                s;
    int                d;
    int                m;
    int                base;
    int                i;
    s = 0;
    for (i = 0; i < n - 1; i++) begin
      t.top_face    = FACE_W'($urandom_range(0, 7));
      t.bottom_face = FACE_W'($urandom_range(0, 7));
      t.last_tile   = 1'b0;
      d = int'(t.top_face) - int'(t.bottom_face);
      if (s + d > 7 || s + d < -7) begin
        swap          = t.top_face;
        t.top_face    = t.bottom_face;
        t.bottom_face = swap;
        d = -d;
      end
      s += d;
      send_tile(t, 1'b0, '0);
    end
    m = (s < 0) ? -s : s;
    base = $urandom_range(0, 7 - m);
    d = $urandom_range(0, 1) ? s : -s;
    if (d >= 0) begin
      t.top_face    = FACE_W'(base + d);
      t.bottom_face = FACE_W'(base);
    end else begin
      t.top_face    = FACE_W'(base);
      t.bottom_face = FACE_W'(base - d);
    end
    t.last_tile = (dropped == 0);
    send_tile(t, 1'b0, '0);
    for (i = 0; i < dropped; i++) begin
      t.top_face    = FACE_W'($urandom_range(0, 7));
      t.bottom_face = FACE_W'($urandom_range(0, 7));
      t.last_tile   = (i == dropped - 1);
      send_tile(t, 1'b0, '0);
    end
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_left == 0) stall_left = idle_length();
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result diff %0d mask %h count %0d", $time,
                 result.least_difference, result.flip_mask, result.flipped_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.least_difference !== want.least_difference)
          report_field("least_difference", want.least_difference, result.least_difference);
        if (result.flip_mask !== want.flip_mask)
          report_field("flip_mask", want.flip_mask, result.flip_mask);
        if (result.flipped_count !== want.flipped_count)
          report_field("flipped_count", want.flipped_count, result.flipped_count);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("** domino_flip_balance_search: FAILED **");
      $finish;
    end
  end

  initial begin
    tile_t t;
    int    i;
    int    kind;
    bit    pressed;
    rst            = 1'b1;
    tile_valid     = 1'b0;
    tile           = '0;
    result_stall   = 1'b0;
    held_count     = 0;
    mismatch_count = 0;
    tiles_sent     = 0;
    stall_left     = 0;
    cycle_count    = 0;
    quiet          = 1'b0;
    pressed        = 1'b0;

    // Directed table: single tiles at the face extremes, small balanced sets
    add_row(0, 0, 1, 1, 0, 0, 0);
    add_row(7, 0, 1, 1, 7, 0, 0);
    add_row(0, 7, 1, 1, 7, 0, 0);
    add_row(6, 6, 1, 1, 0, 0, 0);
    add_row(7, 0, 0, 0, 0, 0, 0);
    add_row(0, 7, 1, 1, 0, 0, 0);
    // Zero only with tile 2 flipped
    add_row(7, 0, 0, 0, 0, 0, 0);
    add_row(7, 0, 1, 1, 0, 2, 1);
    add_row(5, 2, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, 0, 0);
    add_row(3, 7, 1, 1, 0, 0, 0);
    // No flip does better than the start pattern
    add_row(4, 1, 0, 0, 0, 0, 0);
    add_row(2, 2, 1, 1, 3, 0, 0);
    add_row(6, 3, 0, 0, 0, 0, 0);
    add_row(1, 4, 0, 0, 0, 0, 0);
    add_row(2, 0, 1, 0, 0, 0, 0);
    add_row(7, 7, 0, 0, 0, 0, 0);
    add_row(5, 0, 0, 0, 0, 0, 0);
    add_row(0, 3, 0, 0, 0, 0, 0);
    add_row(6, 1, 1, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_tile(directed_rows[k].t, directed_rows[k].typed, directed_rows[k].want);

    // Full set of identical heavy tiles; two more are dropped, the mark on the last
    t.top_face    = 3'd7;
    t.bottom_face = 3'd0;
    t.last_tile   = 1'b0;
    for (i = 0; i < TILE_SLOTS; i++) send_tile(t, 1'b0, '0);
    t.top_face    = 3'd0;
    t.bottom_face = 3'd7;
    send_tile(t, 1'b0, '0);
    t.top_face    = 3'd3;
    t.bottom_face = 3'd5;
    t.last_tile   = 1'b1;
    send_tile(t, 1'b1, '{least_difference: 8'd0, flip_mask: 28'hFFFC000,
                         flipped_count: 5'd14});
    drain_results();

    // Random sets, mostly small, a few large balanced or overflowing ones
    tiles_sent = 0;
    while (tiles_sent < RANDOM_TILES) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      if ((!pressed && tiles_sent >= RANDOM_TILES / 2) || $urandom_range(0, 29) == 0) begin
        drain_results();
        pressed = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70)
        send_random_set($urandom_range(1, 8));
      else if (kind < 85)
        send_random_set($urandom_range(9, 12));
      else if (kind < 95)
        send_balanced_set($urandom_range(13, TILE_SLOTS), 0);
      else
        send_balanced_set(TILE_SLOTS, $urandom_range(1, 3));
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("** domino_flip_balance_search: PASSED **");
    else
      $display("** domino_flip_balance_search: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dfb_pkg.sv
src/dfb_ram.sv
src/domino_flip_balance_search.sv
verif/domino_flip_balance_search_test.sv
